FILE: rtl/second_order_follow_filter_top_assert.svh
// Assertion macros shared by the RTL of the follow filter.
`ifndef SECOND_ORDER_FOLLOW_FILTER_TOP_ASSERT_SVH
`define SECOND_ORDER_FOLLOW_FILTER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SOFL_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("follow filter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SOFL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("follow filter assertion failed");

`endif

FILE: rtl/sofl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sofl_pkg;

   localparam int OPA_W     = 33;
   localparam int OPB_W     = 49;
   localparam int PROD_W    = OPA_W + OPA_W;
   localparam int WIDE_W    = PROD_W + 1;
   localparam int MUL_STEPS = OPA_W;
   localparam int DIV_STEPS = OPB_W;
   localparam int CNT_W     = 6;

   // 1.1 in Q16.16.
   localparam logic [OPA_W-1:0] ONE_POINT_ONE_Q16 = 33'd72090;

   localparam logic signed [WIDE_W-1:0] SAT_MAX = 67'sd2147483647;
   localparam logic signed [WIDE_W-1:0] SAT_MIN = -67'sd2147483648;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TT,
      ST_TK,
      ST_BND,
      ST_XD,
      ST_PV,
      ST_KX,
      ST_KV,
      ST_TA,
      ST_DV,
      ST_OUT
   } sofl_state_type;

   typedef enum logic {
      OP_MUL,
      OP_DIV
   } sofl_op_type;

   typedef enum logic [1:0] {
      CSR_DAMPING,
      CSR_INERTIA,
      CSR_ANTICIPATION
   } sofl_csr_type;

   typedef struct packed {
      logic              start;
      sofl_op_type       op;
      logic [OPA_W-1:0]  opa;
      logic [OPB_W-1:0]  opb;
   } sofl_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sofl_status_type;

   function automatic logic signed [WIDE_W-1:0] signed_of(input logic [PROD_W-1:0] mag,
                                                           input logic neg);
      logic signed [WIDE_W-1:0] s;
      s = $signed({1'b0, mag});
      return neg ? -s : s;
   endfunction

   function automatic logic signed [WIDE_W-1:0] wide32(input logic [31:0] v);
      return $signed({{(WIDE_W-32){v[31]}}, v});
   endfunction

   function automatic logic [31:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'h7fff_ffff;
      end else if (v < SAT_MIN) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [OPA_W-1:0] mag33(input logic signed [OPA_W-1:0] v);
      logic signed [OPA_W-1:0] n;
      n = -v;
      return v[OPA_W-1] ? OPA_W'(n) : OPA_W'(v);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/sofl_serial_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared arithmetic unit that retires one bit per cycle: a shift-and-add
// multiplier of two 33-bit magnitudes and a restoring divider of a 49-bit
// dividend by a 33-bit divisor.
module sofl_serial_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sofl_pkg::sofl_cmd_type        cmd,
   output      sofl_pkg::sofl_status_type     status,
   output      logic [sofl_pkg::PROD_W-1:0]   result
);
   import sofl_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   sofl_op_type         op_ff, op_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [OPA_W-1:0]    opa_ff, opa_in;
   logic [OPB_W-1:0]    opb_ff, opb_in;
   logic [PROD_W-1:0]   acc_ff, acc_in;

   logic [OPA_W:0]      mul_hi;
   logic [OPA_W-1:0]    trial;
   logic                fits;
   logic [OPA_W-1:0]    rem_next;
   logic                last;

   always_comb begin
      mul_hi   = {1'b0, acc_ff[PROD_W-1:OPA_W]} + (opb_ff[0] ? {1'b0, opa_ff} : '0);
      trial    = {acc_ff[OPA_W-2:0], opb_ff[OPB_W-1]};
      fits     = trial >= opa_ff;
      rem_next = fits ? trial - opa_ff : trial;
      last     = (op_ff == OP_MUL) ? (cnt_ff == CNT_W'(MUL_STEPS - 1))
                                   : (cnt_ff == CNT_W'(DIV_STEPS - 1));

      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      acc_in  = acc_ff;

      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = '0;
         opa_in  = cmd.opa;
         opb_in  = cmd.opb;
         acc_in  = '0;
      end else if (busy_ff) begin
         case (op_ff)
            OP_MUL: begin
               acc_in = {mul_hi, acc_ff[OPA_W-1:1]};
               opb_in = opb_ff >> 1;
            end
            OP_DIV: begin
               // The remainder sits in the low bits; quotient bits enter the dividend.
               acc_in = {{(PROD_W-OPA_W){1'b0}}, rem_next};
               opb_in = {opb_ff[OPB_W-2:0], fits};
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      acc_ff <= acc_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign result = (op_ff == OP_MUL) ? acc_ff : {{(PROD_W-OPB_W){1'b0}}, opb_ff};

endmodule

`default_nettype wire

FILE: rtl/second_order_follow_filter_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-axis second-order follower in Q16.16 fixed point.
// The req channel carries one transaction per update: a time step, a target
// point and a restart flag in tuser. The rsp channel returns one transaction
// with the filtered position and velocity of both axes. The csr port writes
// the gains k1, k2 and k3 and must be used only while the block is idle;
// the block itself does not enforce this. One item is in work at a time.
// A zero time step skips the arithmetic and goes straight to the output
// state. Otherwise all products and quotients go through one shared
// bit-serial multiply/divide unit: 11 multiplies and 4 divides, and a new
// item is taken only after the last one has left for the output register.
// A finished result sits in an output register; the next item is accepted
// while it waits, and the block holds its next result until the receiver
// takes the pending one. Reset restores k1 = 1.0, k2 = 1.0, k3 = 0, clears
// position, velocity and history, and treats the next item as the first.
module second_order_follow_filter_top (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output      logic          req_tready,
   input  wire logic [79:0]   req_tdata,   // time_step, target_x, target_y
   input  wire logic [0:0]    req_tuser,   // restart
   output      logic          rsp_tvalid,
   input  wire logic          rsp_tready,
   output      logic [127:0]  rsp_tdata,   // out_x, out_y, rate_x, rate_y
   input  wire logic          csr_we,
   input  wire logic [1:0]    csr_index,
   input  wire logic [31:0]   csr_wdata
);
   import sofl_pkg::*;

   sofl_state_type      state_ff, state_in;
   logic                go_ff, go_in;
   logic                axis_ff;

   logic [31:0]         k1_ff, k2_ff, k3_ff;
   logic                fresh_ff;
   logic [31:0]         prev_ff [2];
   logic [31:0]         pos_ff [2];
   logic [31:0]         vel_ff [2];

   logic [15:0]         t_ff;
   logic [31:0]         tgt_ff [2];
   logic [OPA_W-1:0]    sum_ff;
   logic [31:0]         k2s_ff;
   logic [31:0]         xd_ff;
   logic signed [WIDE_W-1:0] kx_ff;
   logic [31:0]         a_ff;
   logic [OPB_W-1:0]    ta_ff;

   logic                rsp_valid_ff;
   logic [127:0]        rsp_data_ff;

   sofl_cmd_type        cmd;
   sofl_status_type     status;
   logic [PROD_W-1:0]   res;

   logic                accept;
   logic                arith;
   logic                out_load;
   logic                fresh_eff;
   logic [15:0]         req_t;
   logic [31:0]         req_tgt [2];
   logic signed [OPA_W-1:0] diff;
   logic [OPA_W-1:0]    diff_mag, vel_mag, k3_mag, xd_mag, a_mag;
   logic [OPA_W-1:0]    t_ext;
   logic [PROD_W-1:0]   bnd_full;
   logic [31:0]         bound, k2_max;
   logic signed [WIDE_W-1:0] kv;

   sofl_serial_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status),
      .result (res)
   );

   assign req_t      = req_tdata[15:0];
   assign req_tgt[0] = req_tdata[47:16];
   assign req_tgt[1] = req_tdata[79:48];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign fresh_eff  = fresh_ff || req_tuser[0];
   assign arith      = (state_ff != ST_IDLE) && (state_ff != ST_OUT);
   assign out_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      diff     = $signed({tgt_ff[axis_ff][31], tgt_ff[axis_ff]})
               - $signed({prev_ff[axis_ff][31], prev_ff[axis_ff]});
      diff_mag = mag33(diff);
      vel_mag  = mag33($signed({vel_ff[axis_ff][31], vel_ff[axis_ff]}));
      k3_mag   = mag33($signed({k3_ff[31], k3_ff}));
      xd_mag   = mag33($signed({xd_ff[31], xd_ff}));
      a_mag    = mag33($signed({a_ff[31], a_ff}));
      t_ext    = {{(OPA_W-16){1'b0}}, t_ff};

      // Stability bound on k2, saturated to 32 bits unsigned.
      bnd_full = res >> 16;
      bound    = (|bnd_full[PROD_W-1:32]) ? 32'hffff_ffff : bnd_full[31:0];
      k2_max   = (bound > k2_ff) ? bound : k2_ff;

      kv = signed_of(res, vel_ff[axis_ff][31]) >>> 16;
   end

   always_comb begin
      cmd.start = arith && !go_ff;
      cmd.op    = OP_MUL;
      cmd.opa   = t_ext;
      cmd.opb   = {{(OPB_W-OPA_W){1'b0}}, t_ext};
      unique case (state_ff)
         ST_TK: begin
            cmd.opa = {1'b0, k1_ff};
         end
         ST_BND: begin
            cmd.opa = ONE_POINT_ONE_Q16;
            cmd.opb = {{(OPB_W-OPA_W){1'b0}}, sum_ff};
         end
         ST_XD: begin
            cmd.op  = OP_DIV;
            cmd.opb = {diff_mag, 16'd0};
         end
         ST_PV: begin
            cmd.opa = vel_mag;
         end
         ST_KX: begin
            cmd.opa = k3_mag;
            cmd.opb = {{(OPB_W-OPA_W){1'b0}}, xd_mag};
         end
         ST_KV: begin
            cmd.opa = {1'b0, k1_ff};
            cmd.opb = {{(OPB_W-OPA_W){1'b0}}, vel_mag};
         end
         ST_TA: begin
            cmd.opa = a_mag;
         end
         ST_DV: begin
            cmd.op  = OP_DIV;
            cmd.opa = {1'b0, k2s_ff};
            cmd.opb = ta_ff;
         end
         default: begin
            cmd.op = OP_MUL;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      go_in    = go_ff;
      if (arith && !go_ff) begin
         go_in = 1'b1;
      end else if (status.done) begin
         go_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_t == 16'd0) ? ST_OUT : ST_TT;
            end
         end
         ST_TT:  if (status.done) state_in = ST_TK;
         ST_TK:  if (status.done) state_in = ST_BND;
         ST_BND: if (status.done) state_in = ST_XD;
         ST_XD:  if (status.done) state_in = ST_PV;
         ST_PV:  if (status.done) state_in = ST_KX;
         ST_KX:  if (status.done) state_in = ST_KV;
         ST_KV:  if (status.done) state_in = ST_TA;
         ST_TA:  if (status.done) state_in = ST_DV;
         ST_DV: begin
            if (status.done) begin
               state_in = axis_ff ? ST_OUT : ST_XD;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         go_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
      end
   end

   // Gains and filter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         k1_ff    <= 32'h0001_0000;
         k2_ff    <= 32'h0001_0000;
         k3_ff    <= 32'd0;
         fresh_ff <= 1'b1;
         for (int i = 0; i < 2; i++) begin
            prev_ff[i] <= 32'd0;
            pos_ff[i]  <= 32'd0;
            vel_ff[i]  <= 32'd0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DAMPING:      k1_ff <= csr_wdata;
               CSR_INERTIA:      k2_ff <= csr_wdata;
               CSR_ANTICIPATION: k3_ff <= csr_wdata;
               default: begin
                  k1_ff <= k1_ff;
               end
            endcase
         end
         if (accept) begin
            fresh_ff <= 1'b0;
            if (fresh_eff) begin
               for (int i = 0; i < 2; i++) begin
                  prev_ff[i] <= req_tgt[i];
                  pos_ff[i]  <= req_tgt[i];
               end
            end
         end
         if (status.done) begin
            case (state_ff)
               ST_XD: prev_ff[axis_ff] <= tgt_ff[axis_ff];
               ST_PV: begin
                  pos_ff[axis_ff] <= sat32(wide32(pos_ff[axis_ff])
                     + (signed_of(res, vel_ff[axis_ff][31]) >>> 16));
               end
               ST_DV: begin
                  vel_ff[axis_ff] <= sat32(wide32(vel_ff[axis_ff])
                     + signed_of(res, a_ff[31]));
               end
               default: begin
                  fresh_ff <= fresh_ff;
               end
            endcase
         end
      end
   end

   // Working registers of one item.
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff <= 1'b0;
      end else if (accept) begin
         axis_ff <= 1'b0;
      end else if (status.done && state_ff == ST_DV) begin
         axis_ff <= 1'b1;
      end
      if (accept) begin
         t_ff      <= req_t;
         tgt_ff[0] <= req_tgt[0];
         tgt_ff[1] <= req_tgt[1];
      end
      if (status.done) begin
         case (state_ff)
            ST_TT:  sum_ff <= OPA_W'(res >> 18);
            ST_TK:  sum_ff <= sum_ff + OPA_W'(res >> 17);
            ST_BND: k2s_ff <= (k2_max == 32'd0) ? 32'd1 : k2_max;
            ST_XD:  xd_ff  <= sat32(signed_of(res, diff[OPA_W-1]));
            ST_KX:  kx_ff  <= signed_of(res, k3_ff[31] ^ xd_ff[31]) >>> 16;
            ST_KV: begin
               a_ff <= sat32(wide32(tgt_ff[axis_ff]) + kx_ff
                             - wide32(pos_ff[axis_ff]) - kv);
            end
            ST_TA:  ta_ff  <= res[OPB_W-1:0];
            default: begin
               ta_ff <= ta_ff;
            end
         endcase
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_data_ff <= {vel_ff[1], vel_ff[0],
                         (t_ff == 16'd0) ? tgt_ff[1] : pos_ff[1],
                         (t_ff == 16'd0) ? tgt_ff[0] : pos_ff[0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`include "second_order_follow_filter_top_assert.svh"

   `SOFL_ASSERT_IMPL(a_done_only_when_launched, clock, reset, status.done, go_ff && arith)
   `SOFL_ASSERT_IMPL(a_divisor_nonzero, clock, reset, state_ff == ST_DV, k2s_ff != 32'd0)
   `SOFL_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept, state_ff != ST_IDLE)

endmodule

`default_nettype wire
